@@ rtl/core/hpb_pkg.sv @@
`timescale 1ns / 1ps
// package: shared types, constants and controller states for the percentile bounds core
package hpb_pkg;
    localparam int BIN_COUNT  = 256;
    localparam int BIN_W      = 8;
    localparam int CNT_W      = 23;
    localparam int SUM_W      = 25;
    localparam logic [CNT_W-1:0] COUNT_CAP = 23'd4194304;

    localparam logic CFG_COLOR_MODE = 1'b0;
    localparam logic CFG_CLIP_COUNT = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_pixel;
    } pixel_t;

    typedef struct packed {
        logic [7:0] low_level;
        logic [7:0] high_level;
        logic       single_color;
        logic       bound_missing;
    } result_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_ACCUM,
        ST_SETTLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic count_en;
        logic scan_start;
        logic scan_en;
        logic clear_en;
        logic [BIN_W-1:0] addr;
        logic finish;
    } hpb_cmd_t;
endpackage

@@ rtl/core/hpb_ctrl.sv @@
`timescale 1ns / 1ps
// controller: clearing pass, pixel accumulation, scan and result hand-off
module hpb_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_last,
    input  logic                     out_stall,
    output logic                     in_stall,
    output logic                     out_valid,
    output hpb_pkg::hpb_cmd_t        cmd
);
    hpb_pkg::state_t state_reg, state_next;
    logic [hpb_pkg::BIN_W-1:0] addr_reg, addr_next;
    logic out_valid_reg, out_valid_next;

    assign out_valid = out_valid_reg;

    // state register and result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hpb_pkg::ST_CLEAR;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        in_stall       = 1'b1;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.addr       = addr_reg;
        case (state_reg)
            hpb_pkg::ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == hpb_pkg::BIN_W'(hpb_pkg::BIN_COUNT - 1))
                    state_next = hpb_pkg::ST_ACCUM;
            end
            hpb_pkg::ST_ACCUM:
            begin
                in_stall = 1'b0;
                cmd.count_en = in_valid;
                if (in_valid && in_last)
                begin
                    state_next = hpb_pkg::ST_SETTLE;
                    addr_next  = '0;
                end
            end
            // let the last pixel's count reach memory before bin 0 is read
            hpb_pkg::ST_SETTLE:
            begin
                state_next = hpb_pkg::ST_SCAN;
            end
            hpb_pkg::ST_SCAN:
            begin
                cmd.scan_en    = 1'b1;
                cmd.scan_start = (addr_reg == '0);
                addr_next = addr_reg + 1'b1;
                if (addr_reg == hpb_pkg::BIN_W'(hpb_pkg::BIN_COUNT - 1))
                    state_next = hpb_pkg::ST_DRAIN;
            end
            hpb_pkg::ST_DRAIN:
            begin
                state_next = hpb_pkg::ST_FINISH;
            end
            // load the output register once the previous result has left
            hpb_pkg::ST_FINISH:
            begin
                if (!out_valid_next)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = hpb_pkg::ST_CLEAR;
                    addr_next      = '0;
                end
            end
            default:
            begin
                state_next = hpb_pkg::ST_CLEAR;
                addr_next  = '0;
            end
        endcase
    end
endmodule

@@ rtl/core/hpb_datapath.sv @@
`timescale 1ns / 1ps
// datapath: histogram memories, uniformity tracking and bound search
module hpb_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hpb_pkg::hpb_cmd_t    cmd,
    input  hpb_pkg::pixel_t      pix,
    input  logic                 color_mode,
    input  logic [22:0]          clip_count,
    output hpb_pkg::result_t     result
);
    localparam int W = hpb_pkg::BIN_W;
    localparam int C = hpb_pkg::CNT_W;
    localparam int S = hpb_pkg::SUM_W;

    // per channel: low-side memory and a high-side copy (written by bin, read by 255-addr in the scan)
    logic [C-1:0] lo_mem [3][hpb_pkg::BIN_COUNT];
    logic [C-1:0] hi_mem [3][hpb_pkg::BIN_COUNT];
    logic [C-1:0] lo_rd_reg [3];
    logic [C-1:0] hi_rd_reg [3];

    // pixel pipeline: stage 1 reads counts, stage 2 writes back
    logic         p1_valid_reg;
    logic [W-1:0] p1_smp_reg [3];
    logic         p1_en_reg  [3];
    logic         fwd_reg    [3];
    logic [C-1:0] wr_cnt_reg [3];

    // scan pipeline
    logic         s1_valid_reg;
    logic         s1_start_reg;
    logic [W-1:0] s1_addr_reg;
    logic         s1_mode_reg;
    logic [S-1:0] lo_sum_reg [3];
    logic [S-1:0] hi_sum_reg [3];
    logic         lo_fnd_reg [3];
    logic         hi_fnd_reg [3];
    logic [W-1:0] lo_bin_reg [3];
    logic [W-1:0] hi_bin_reg [3];

    logic [23:0] first_reg;
    logic        started_reg;
    logic        uniform_reg;

    logic [W-1:0] smp [3];
    logic [W-1:0] rd_addr [3];
    logic [C-1:0] cur_cnt [3];
    logic [C-1:0] inc_cnt [3];
    logic [23:0]  pix_word, ref_word;
    logic         mism;

    always_comb
    begin
        smp[0] = pix.red;
        smp[1] = pix.green;
        smp[2] = pix.blue;
        pix_word = color_mode ? {pix.blue, pix.green, pix.red} : {16'd0, pix.red};
        ref_word = started_reg ? first_reg : {pix.blue, pix.green, pix.red};
        if (!color_mode)
            ref_word = {16'd0, ref_word[7:0]};
        mism = (pix_word != ref_word);
        for (int k = 0; k < 3; k++)
        begin
            rd_addr[k] = cmd.count_en ? smp[k] : cmd.addr;
            // same-bin back-to-back pixels take the just-written count
            cur_cnt[k] = fwd_reg[k] ? wr_cnt_reg[k] : lo_rd_reg[k];
            inc_cnt[k] = (cur_cnt[k] < hpb_pkg::COUNT_CAP) ? cur_cnt[k] + 1'b1 : cur_cnt[k];
        end
    end

    // memory read and write ports
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            lo_rd_reg[k] <= lo_mem[k][rd_addr[k]];
            hi_rd_reg[k] <= hi_mem[k][~cmd.addr];
            if (cmd.clear_en)
            begin
                lo_mem[k][cmd.addr] <= '0;
                hi_mem[k][cmd.addr] <= '0;
            end
            else if (p1_valid_reg && p1_en_reg[k])
            begin
                lo_mem[k][p1_smp_reg[k]] <= inc_cnt[k];
                hi_mem[k][p1_smp_reg[k]] <= inc_cnt[k];
            end
            wr_cnt_reg[k] <= inc_cnt[k];
            fwd_reg[k]    <= cmd.count_en && p1_valid_reg && p1_en_reg[k]
                             && (p1_smp_reg[k] == smp[k]) && (k == 0 || color_mode);
            p1_smp_reg[k] <= smp[k];
            p1_en_reg[k]  <= (k == 0) || color_mode;
        end
    end

    // control registers of both pipelines and frame tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s1_start_reg <= 1'b0;
            started_reg  <= 1'b0;
            uniform_reg  <= 1'b1;
            first_reg    <= '0;
        end
        else
        begin
            p1_valid_reg <= cmd.count_en;
            s1_valid_reg <= cmd.scan_en;
            s1_start_reg <= cmd.scan_start;
            if (cmd.count_en)
            begin
                if (!started_reg)
                    first_reg <= {pix.blue, pix.green, pix.red};
                started_reg <= 1'b1;
                if (mism)
                    uniform_reg <= 1'b0;
            end
            if (cmd.finish)
            begin
                started_reg <= 1'b0;
                uniform_reg <= 1'b1;
                first_reg   <= '0;
            end
        end
    end

    // running sums from both ends, one bin per cycle, and the combined result
    always_ff @(posedge clk)
    begin
        s1_addr_reg <= cmd.addr;
        if (cmd.scan_start)
            s1_mode_reg <= color_mode;
        if (s1_valid_reg)
        begin
            for (int k = 0; k < 3; k++)
            begin
                logic [S-1:0] ls, hs;
                ls = (s1_start_reg ? '0 : lo_sum_reg[k]) + S'(lo_rd_reg[k]);
                hs = (s1_start_reg ? '0 : hi_sum_reg[k]) + S'(hi_rd_reg[k]);
                lo_sum_reg[k] <= ls;
                hi_sum_reg[k] <= hs;
                if (s1_start_reg)
                begin
                    lo_fnd_reg[k] <= 1'b0;
                    hi_fnd_reg[k] <= 1'b0;
                end
                if ((s1_start_reg || !lo_fnd_reg[k]) && ls > S'(clip_count))
                begin
                    lo_fnd_reg[k] <= 1'b1;
                    lo_bin_reg[k] <= s1_addr_reg;
                end
                if ((s1_start_reg || !hi_fnd_reg[k]) && hs > S'(clip_count))
                begin
                    hi_fnd_reg[k] <= 1'b1;
                    hi_bin_reg[k] <= ~s1_addr_reg;
                end
            end
        end
        // combine channels (only red when colour mode is off)
        if (cmd.finish)
        begin
            logic miss;
            logic [W-1:0] lo, hi;
            miss = !(lo_fnd_reg[0] && hi_fnd_reg[0]);
            lo = lo_bin_reg[0];
            hi = hi_bin_reg[0];
            if (s1_mode_reg)
            begin
                for (int k = 1; k < 3; k++)
                begin
                    miss = miss || !(lo_fnd_reg[k] && hi_fnd_reg[k]);
                    if (lo_bin_reg[k] < lo) lo = lo_bin_reg[k];
                    if (hi_bin_reg[k] > hi) hi = hi_bin_reg[k];
                end
            end
            result.low_level     <= miss ? '0 : lo;
            result.high_level    <= miss ? '0 : hi;
            result.bound_missing <= miss;
            result.single_color  <= uniform_reg;
        end
    end
endmodule

@@ rtl/core/histogram_percentile_bounds_core.sv @@
`timescale 1ns / 1ps
// top level: percentile clip bounds core
// Pixels are taken one per cycle during a frame. After reset, and after each
// frame result is produced, a clearing pass over all 256 bins wipes the
// histograms and no pixel is accepted. The pixel flagged last closes the
// input for a settling state and a scan of the histogram memories (one bin
// per cycle from both ends of every channel), then a drain state; the result
// is loaded once the output register is free. The result waits in an output
// register until taken, so a stalled result only holds back the end of the
// following frame.
// Configuration writes are accepted every cycle but belong between pixels or
// frames, never while a scan is running.
module histogram_percentile_bounds_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  hpb_pkg::pixel_t      in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output hpb_pkg::result_t     out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [22:0]          cfg_data
);
    hpb_pkg::hpb_cmd_t cmd;
    logic        color_mode_reg;
    logic [22:0] clip_count_reg;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg <= 1'b0;
            clip_count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                hpb_pkg::CFG_COLOR_MODE: color_mode_reg <= cfg_data[0];
                hpb_pkg::CFG_CLIP_COUNT: clip_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    hpb_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid),
        .in_last(in_data.last_pixel), .out_stall(out_stall),
        .in_stall(in_stall), .out_valid(out_valid), .cmd(cmd)
    );

    hpb_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .pix(in_data),
        .color_mode(color_mode_reg), .clip_count(clip_count_reg), .result(out_data)
    );

    // an offered result is fully defined
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown(out_data)) else $error("result has unknown bits");
    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed under stall");
    // last pixel closes the input
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.last_pixel |=> in_stall)
        else $error("input open after last pixel");
endmodule
